[rtl/core/assert_macros.svh]
// assertion helpers, empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds, consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/alse_pkg.sv]
package alse_pkg;

    // default sizes
    localparam int LED_COUNT_DEF  = 16;
    localparam int FRAME_BITS_DEF = 384;
    localparam int BITS_PER_LED   = 24;

    // item modes
    localparam logic [1:0] MODE_WR24  = 2'd0;
    localparam logic [1:0] MODE_WR6   = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_BIT_PERIOD = 2'd0;
    localparam logic [1:0] CFG_ZERO_HIGH  = 2'd1;
    localparam logic [1:0] CFG_ONE_HIGH   = 2'd2;

    // register reset values
    localparam logic [7:0] BIT_PERIOD_RST = 8'd20;
    localparam logic [7:0] ZERO_HIGH_RST  = 8'd5;
    localparam logic [7:0] ONE_HIGH_RST   = 8'd10;

    typedef logic [23:0] color_t;

    typedef struct packed {
        logic [7:0] bit_period;
        logic [7:0] zero_high;
        logic [7:0] one_high;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic tick;
    } tx_ctrl_t;

    typedef struct packed {
        logic line;
        logic busy;
    } tx_status_t;

    // rrggbb to 24-bit rgb, each 2-bit channel times 85 (channel repeated four times)
    function automatic color_t expand6(input logic [5:0] c6);
        color_t c;
        c = {{4{c6[5:4]}}, {4{c6[3:2]}}, {4{c6[1:0]}}};
        return c;
    endfunction

endpackage

[rtl/core/alse_frame_tx.sv]
module alse_frame_tx
    import alse_pkg::*;
#(
    parameter int LED_COUNT  = LED_COUNT_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  tx_ctrl_t   ctrl,
    input  cfg_t       cfg,
    input  color_t     snap [LED_COUNT],
    output tx_status_t status
);

    localparam int LED_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int BIT_W   = $clog2(FRAME_BITS);
    localparam int LAST_LED = (FRAME_BITS - 1) / BITS_PER_LED;
    localparam int LW_A    = $clog2(LED_COUNT + 1);
    localparam int LW_B    = $clog2(LAST_LED + 2);
    localparam int LEDC_W  = (LW_A > LW_B) ? LW_A : LW_B;

    color_t            frame_store_reg [LED_COUNT];
    logic [BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [4:0]        pos_reg, pos_next;
    logic [LEDC_W-1:0] led_reg, led_next;
    logic [7:0]        tick_reg, tick_next;
    logic              sending_reg, sending_next;

    color_t     cur;
    logic [23:0] grb;
    logic       led_ok;
    logic       data_bit;
    logic [7:0] high;
    logic [7:0] tick_inc;
    logic       bit_done;
    logic       last_bit;
    logic       line;

    always_comb
    begin
        cur      = frame_store_reg[led_reg[LED_W-1:0]];
        led_ok   = led_reg < LEDC_W'(LED_COUNT);
        grb      = {cur[15:8], cur[23:16], cur[7:0]};
        data_bit = led_ok & grb[5'd23 - pos_reg];
        high     = data_bit ? cfg.one_high : cfg.zero_high;
        line     = ctrl.tick & sending_reg & (tick_reg < high);
        tick_inc = tick_reg + 8'd1;
        bit_done = (tick_inc >= cfg.bit_period) || (tick_inc == 8'd0);
        last_bit = bit_cnt_reg == BIT_W'(FRAME_BITS - 1);

        bit_cnt_next = bit_cnt_reg;
        pos_next     = pos_reg;
        led_next     = led_reg;
        tick_next    = tick_reg;
        sending_next = sending_reg;

        if (ctrl.start)
        begin
            bit_cnt_next = '0;
            pos_next     = '0;
            led_next     = '0;
            tick_next    = '0;
            sending_next = 1'b1;
        end
        else if (ctrl.tick && sending_reg)
        begin
            tick_next = tick_inc;
            if (bit_done)
            begin
                tick_next = '0;
                if (last_bit)
                begin
                    // frame complete, back to idle
                    bit_cnt_next = '0;
                    pos_next     = '0;
                    led_next     = '0;
                    sending_next = 1'b0;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                    if (pos_reg == 5'(BITS_PER_LED - 1))
                    begin
                        pos_next = '0;
                        led_next = led_reg + LEDC_W'(1);
                    end
                    else
                    begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            pos_reg     <= '0;
            led_reg     <= '0;
            tick_reg    <= '0;
            sending_reg <= 1'b0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            pos_reg     <= pos_next;
            led_reg     <= led_next;
            tick_reg    <= tick_next;
            sending_reg <= sending_next;
        end
    end

    // snapshot of the colour store at start
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                frame_store_reg[i] <= snap[i];
            end
        end
    end

    assign status.line = line;
    assign status.busy = sending_next;

endmodule

[rtl/core/addressable_led_strip_encoder_core.sv]
// channel | signals                          | direction | accepted when
// in      | mode, led_index, color           | input     | in_valid & in_ready
// out     | line_level, busy_res, read_color | output    | out_valid & out_ready
// cfg     | cfg_we, cfg_index, cfg_data      | input     | cfg_we
// one item per cycle sustained while out_ready stays high: decode, store and bit timer are one short pass
// an accepted item waits in the input register until the result register is free or draining;
//   it moves there at the same edge where the colour store and line timer update
// reset (async, active low) clears colour store, counters and control; the frame
//   snapshot has no reset and is loaded by every start item
// in_ready drops only when both registers hold items and out_ready is low
module addressable_led_strip_encoder_core
    import alse_pkg::*;
#(
    parameter int LED_COUNT  = LED_COUNT_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [3:0]  led_index,
    input  logic [23:0] color,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        line_level,
    output logic        busy_res,
    output logic [23:0] read_color,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

`include "assert_macros.svh"

    localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period <= BIT_PERIOD_RST;
            cfg_reg.zero_high  <= ZERO_HIGH_RST;
            cfg_reg.one_high   <= ONE_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIT_PERIOD: cfg_reg.bit_period <= cfg_data;
                CFG_ZERO_HIGH:  cfg_reg.zero_high  <= cfg_data;
                CFG_ONE_HIGH:   cfg_reg.one_high   <= cfg_data;
                default:        ; // writes past the register list are dropped
            endcase
        end
    end

    // input register
    logic        s1_valid_reg;
    logic [1:0]  s1_mode_reg;
    logic [3:0]  s1_index_reg;
    logic [23:0] s1_color_reg;

    // result register
    logic        out_valid_reg;
    logic        line_level_reg;
    logic        busy_res_reg;
    logic [23:0] read_color_reg;

    // the input item moves to the result register when that one is free or draining
    logic advance;
    assign advance  = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~s1_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_mode_reg  <= mode;
            s1_index_reg <= led_index;
            s1_color_reg <= color;
        end
    end

    // colour store and item decode
    color_t     color_store_reg [LED_COUNT];
    logic [8:0] idx_ext;
    logic       idx_ok;
    color_t     rd_color;
    color_t     wr_color;
    logic       wr_en;
    tx_ctrl_t   tx_ctrl;
    tx_status_t tx_status;

    always_comb
    begin
        idx_ext  = {5'd0, s1_index_reg};
        idx_ok   = idx_ext < 9'(LED_COUNT);
        // readback is the colour before this item's write; out of range reads zero
        rd_color = idx_ok ? color_store_reg[idx_ext[LED_W-1:0]] : '0;
        wr_color = s1_color_reg;
        wr_en    = 1'b0;
        tx_ctrl  = '0;
        unique case (s1_mode_reg)
            MODE_WR24:
            begin
                wr_en = advance & idx_ok;
            end
            MODE_WR6:
            begin
                wr_color = expand6(s1_color_reg[5:0]);
                wr_en    = advance & idx_ok;
            end
            MODE_START:
            begin
                tx_ctrl.start = advance;
            end
            MODE_TICK:
            begin
                tx_ctrl.tick = advance;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                color_store_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            color_store_reg[idx_ext[LED_W-1:0]] <= wr_color;
        end
    end

    // frame snapshot, bit timer and line encoder
    alse_frame_tx #(
        .LED_COUNT  (LED_COUNT),
        .FRAME_BITS (FRAME_BITS)
    ) u_frame_tx (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (tx_ctrl),
        .cfg    (cfg_reg),
        .snap   (color_store_reg),
        .status (tx_status)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            line_level_reg <= tx_status.line;
            busy_res_reg   <= tx_status.busy;
            read_color_reg <= rd_color;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_level = line_level_reg;
    assign busy_res   = busy_res_reg;
    assign read_color = read_color_reg;

    // a moving item always lands in the result register
    `ASSERT_NEXT(a_advance_lands, clk, rst_n, advance, out_valid)
    // a start item always reports the line as busy
    `ASSERT_NEXT(a_start_busy, clk, rst_n, advance && s1_mode_reg == MODE_START, busy_res)
    // only tick items can raise the line
    `ASSERT_NEXT(a_line_tick_only, clk, rst_n, advance && s1_mode_reg != MODE_TICK, !line_level)
    // a blocked input register means a full, stalled result register
    `ASSERT_SAME(a_stall_cause, clk, rst_n, !in_ready, s1_valid_reg && out_valid_reg && !out_ready)

endmodule
